@@ rtl/ussan_pkg.sv @@
// ussan_pkg: shared types and constants of the UTF-8 stream sanitizer.
// No dependencies; used by the front, queue, back and top level through scoped names.
`timescale 1ns / 1ps

package ussan_pkg;

	// Replacement character U+FFFD as UTF-8
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	// Code point limits
	localparam logic [20:0] CP_MIN2     = 21'h00080;
	localparam logic [20:0] CP_MIN3     = 21'h00800;
	localparam logic [20:0] CP_MIN4     = 21'h10000;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
	localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;

	// Sequence lengths announced by a lead byte
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	// Position of a byte inside a replacement character
	localparam logic [1:0] SUB_B0 = 2'd0;
	localparam logic [1:0] SUB_B1 = 2'd1;
	localparam logic [1:0] SUB_B2 = 2'd2;

	// One output run: rep_count replacement characters, then lit_count literal bytes
	typedef struct packed {
		logic [2:0]      rep_count;
		logic [2:0]      lit_count;
		logic [3:0][7:0] lit;
		logic            eot;
	} cmd_t;

endpackage

@@ rtl/ussan_in_if.sv @@
// ussan_in_if: raw byte channel of the sanitizer (valid/ready plus payload).
// No dependencies.
`timescale 1ns / 1ps

interface ussan_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

@@ rtl/ussan_out_if.sv @@
// ussan_out_if: sanitized byte channel of the sanitizer (valid/ready plus payload).
// No dependencies.
`timescale 1ns / 1ps

interface ussan_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_last;

	modport source (output valid, output out_byte, output run_last, output text_last,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input text_last,
		output ready);
endinterface

@@ rtl/ussan_front.sv @@
// ussan_front: accepts raw bytes, tracks the pending sequence, classifies each
// request into an output run. Depends on ussan_pkg and ussan_in_if.
`timescale 1ns / 1ps

module ussan_front (
	input  logic              clk,
	input  logic              arst_n,
	ussan_in_if.sink          raw,
	output logic              push,
	output ussan_pkg::cmd_t   push_cmd,
	input  logic              full
);

	logic [1:0]      cnt_q;
	logic [2:0]      exp_q;
	logic [7:0]      held_q [3];

	logic [1:0]      cnt_d;
	logic [2:0]      exp_d;
	logic            held_we;
	logic [1:0]      held_idx;
	logic            accept;
	logic            pending;
	logic            is_cont;
	logic [2:0]      f_len;
	logic [2:0]      base_rep;
	logic [20:0]     cp;
	logic            seq_ok;
	ussan_pkg::cmd_t cmd;

	assign raw.ready = !full;
	assign accept    = raw.valid && raw.ready;

	assign pending = (cnt_q != 2'd0) && (exp_q >= ussan_pkg::LEN_2) &&
		(exp_q <= ussan_pkg::LEN_4);
	assign is_cont = (raw.in_byte[7:6] == 2'b10);

	always_comb begin
		priority if (raw.in_byte[7:5] == 3'b110) begin
			f_len = ussan_pkg::LEN_2;
		end else if (raw.in_byte[7:4] == 4'b1110) begin
			f_len = ussan_pkg::LEN_3;
		end else if (raw.in_byte[7:3] == 5'b11110) begin
			f_len = ussan_pkg::LEN_4;
		end else begin
			f_len = ussan_pkg::LEN_NONE;
		end
	end

	// code point of the completed sequence, with this byte as the last one
	always_comb begin
		priority if (exp_q == ussan_pkg::LEN_2) begin
			cp = {10'd0, held_q[0][4:0], raw.in_byte[5:0]};
		end else if (exp_q == ussan_pkg::LEN_3) begin
			cp = {5'd0, held_q[0][3:0], held_q[1][5:0], raw.in_byte[5:0]};
		end else begin
			cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], raw.in_byte[5:0]};
		end
		seq_ok = !(cp >= ussan_pkg::CP_SURR_LO && cp <= ussan_pkg::CP_SURR_HI);
		if (exp_q == ussan_pkg::LEN_2 && cp < ussan_pkg::CP_MIN2) seq_ok = 1'b0;
		if (exp_q == ussan_pkg::LEN_3 && cp < ussan_pkg::CP_MIN3) seq_ok = 1'b0;
		if (exp_q == ussan_pkg::LEN_4 &&
			(cp < ussan_pkg::CP_MIN4 || cp > ussan_pkg::CP_MAX)) seq_ok = 1'b0;
	end

	always_comb begin
		cmd       = '0;
		cmd.eot   = raw.end_of_text;
		cnt_d     = cnt_q;
		exp_d     = exp_q;
		held_we   = 1'b0;
		held_idx  = 2'd0;
		base_rep  = (pending && !is_cont) ? {1'b0, cnt_q} : 3'd0;
		if (!pending || !is_cont) begin
			// nothing pending, or a break: flush, then take the byte fresh
			cnt_d         = 2'd0;
			exp_d         = ussan_pkg::LEN_NONE;
			cmd.rep_count = base_rep;
			if (!raw.in_byte[7]) begin
				cmd.lit_count = 3'd1;
				cmd.lit[0]    = raw.in_byte;
			end else if (f_len != ussan_pkg::LEN_NONE) begin
				if (raw.end_of_text) begin
					cmd.rep_count = 3'(base_rep + 3'd1);
				end else begin
					held_we = 1'b1;
					cnt_d   = 2'd1;
					exp_d   = f_len;
				end
			end else begin
				cmd.rep_count = 3'(base_rep + 3'd1);
			end
		end else if (3'({1'b0, cnt_q} + 3'd1) == exp_q) begin
			cnt_d = 2'd0;
			exp_d = ussan_pkg::LEN_NONE;
			if (seq_ok) begin
				cmd.lit_count = exp_q;
				cmd.lit[0]    = held_q[0];
				priority if (exp_q == ussan_pkg::LEN_2) begin
					cmd.lit[1] = raw.in_byte;
				end else if (exp_q == ussan_pkg::LEN_3) begin
					cmd.lit[1] = held_q[1];
					cmd.lit[2] = raw.in_byte;
				end else begin
					cmd.lit[1] = held_q[1];
					cmd.lit[2] = held_q[2];
					cmd.lit[3] = raw.in_byte;
				end
			end else begin
				cmd.rep_count = exp_q;
			end
		end else begin
			// continuation that does not complete the sequence
			held_we  = (cnt_q != 2'd3);
			held_idx = cnt_q;
			if (raw.end_of_text) begin
				cmd.rep_count = 3'({1'b0, cnt_q} + 3'd1);
				cnt_d         = 2'd0;
				exp_d         = ussan_pkg::LEN_NONE;
			end else begin
				cnt_d = 2'(cnt_q + 2'd1);
			end
		end
	end

	assign push     = accept && (cmd.rep_count != 3'd0 || cmd.lit_count != 3'd0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			exp_q <= ussan_pkg::LEN_NONE;
		end else if (accept) begin
			cnt_q <= cnt_d;
			exp_q <= exp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			held_q[held_idx] <= raw.in_byte;
		end
	end

endmodule

@@ rtl/ussan_queue.sv @@
// ussan_queue: small register FIFO of output runs between front and back.
// Depends on ussan_pkg.
`timescale 1ns / 1ps

module ussan_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ussan_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ussan_pkg::cmd_t head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ussan_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");

endmodule

@@ rtl/ussan_back.sv @@
// ussan_back: expands queued runs into output bytes through an output register.
// Depends on ussan_pkg and ussan_out_if.
`timescale 1ns / 1ps

module ussan_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  ussan_pkg::cmd_t head_cmd,
	output logic            pop,
	ussan_out_if.source     clean
);

	logic [2:0] rep_done_q;
	logic [1:0] sub_q;
	logic [2:0] lit_idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       text_last_q;

	logic       in_rep;
	logic       last;
	logic       advance;
	logic [7:0] cur_byte;
	logic [7:0] repl_byte;

	always_comb begin
		unique case (sub_q)
			ussan_pkg::SUB_B0: repl_byte = ussan_pkg::REPL_B0;
			ussan_pkg::SUB_B1: repl_byte = ussan_pkg::REPL_B1;
			ussan_pkg::SUB_B2: repl_byte = ussan_pkg::REPL_B2;
			default:           repl_byte = ussan_pkg::REPL_B2;
		endcase
	end

	assign in_rep   = (rep_done_q < head_cmd.rep_count);
	assign cur_byte = in_rep ? repl_byte : head_cmd.lit[lit_idx_q[1:0]];
	assign last     = in_rep ?
		((rep_done_q == 3'(head_cmd.rep_count - 3'd1)) && (sub_q == ussan_pkg::SUB_B2) &&
			(head_cmd.lit_count == 3'd0)) :
		(lit_idx_q == 3'(head_cmd.lit_count - 3'd1));
	assign advance  = head_valid && (!out_valid_q || clean.ready);
	assign pop      = advance && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_done_q  <= 3'd0;
			sub_q       <= ussan_pkg::SUB_B0;
			lit_idx_q   <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (last) begin
					rep_done_q <= 3'd0;
					sub_q      <= ussan_pkg::SUB_B0;
					lit_idx_q  <= 3'd0;
				end else if (in_rep) begin
					if (sub_q == ussan_pkg::SUB_B2) begin
						sub_q      <= ussan_pkg::SUB_B0;
						rep_done_q <= 3'(rep_done_q + 3'd1);
					end else begin
						sub_q <= 2'(sub_q + 2'd1);
					end
				end else begin
					lit_idx_q <= 3'(lit_idx_q + 3'd1);
				end
			end else if (clean.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q  <= cur_byte;
			run_last_q  <= last;
			text_last_q <= last && head_cmd.eot;
		end
	end

	assign clean.valid     = out_valid_q;
	assign clean.out_byte  = out_byte_q;
	assign clean.run_last  = run_last_q;
	assign clean.text_last = text_last_q;

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != 2'd3) else $error("replacement byte position out of range");
	a_text_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && text_last_q |-> run_last_q) else $error("text end inside a run");
	a_pop_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && run_last_q) else $error("run retired without its last byte");

endmodule

@@ rtl/utf8_stream_sanitizer.sv @@
// utf8_stream_sanitizer: top level of the UTF-8 stream sanitizer.
// Depends on ussan_pkg, ussan_in_if, ussan_out_if, ussan_front, ussan_queue, ussan_back.
//
// Usage:
//   raw   - input request channel: one byte of text per request, end_of_text set on
//           the final byte of a text. Accepted when valid and ready are both high.
//   clean - output channel: one sanitized byte per request. run_last marks the last
//           byte caused by one input byte, text_last the final byte of a text.
//   ASCII and complete valid sequences pass unchanged; bad or cut-off sequences,
//   stray continuation bytes and invalid leads become EF BF BD per offending byte.
// Throughput: the front takes one byte per cycle while the run queue has room. The
//   back emits one output byte per cycle while clean.ready is high, so the sustained
//   input rate falls as N, the bytes an input byte causes (0..12), grows; replacement
//   runs of three bytes per pending byte make N largest, the queue absorbs short bursts.
// Path: an accepted byte's run is first written into the queue, then its first output
//   byte enters the output register, later while earlier runs are still draining.
// Reset: arst_n clears the pending sequence, the queue and the output register.
// Stall: when clean.ready is low the output register holds; the queue fills, and
//   raw.ready drops once QUEUE_DEPTH runs are waiting. Bytes that cause no output
//   (lead and middle bytes of a sequence) still need a free queue slot to enter.
`timescale 1ns / 1ps

module utf8_stream_sanitizer #(
	parameter int QUEUE_DEPTH = 2  // runs buffered between front and back, 1..32
) (
	input  logic         clk,
	input  logic         arst_n,
	ussan_in_if.sink     raw,
	ussan_out_if.source  clean
);

	logic            push;
	logic            full;
	logic            pop;
	logic            head_valid;
	ussan_pkg::cmd_t push_cmd;
	ussan_pkg::cmd_t head_cmd;

	// front: sequence tracking and classification into runs
	ussan_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	// decoupling queue of runs
	ussan_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back: byte-by-byte expansion into the output register
	ussan_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.clean      (clean)
	);

endmodule
